// ===== rtl/ecm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the escape count color map block.
// Used by ecm_div, ecm_poly and escape_count_color_map; depends on nothing.
package ecm_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int FIELD_BITS = 16;
    localparam int LIMIT_BITS = 16;
    localparam int CHAN_BITS  = 8;
    localparam int SCALE_BITS = 13;

    localparam logic [LIMIT_BITS-1:0] MAX_ITER_RESET = 16'd500;

    // Channel scales: 9*255, 15*255 and 17*255 (the blue one is halved later).
    localparam logic [SCALE_BITS-1:0] RED_SCALE   = 13'd2295;
    localparam logic [SCALE_BITS-1:0] GREEN_SCALE = 13'd3825;
    localparam logic [SCALE_BITS-1:0] BLUE_SCALE  = 13'd4335;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

endpackage

// ===== rtl/ecm_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider that forms t = count / max_iterations in Q1.F.
// One quotient bit per stage; depends on ecm_pkg.
module ecm_div #(
    parameter int COUNT_BITS    = ecm_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = ecm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ecm_pkg::FIELD_BITS-1:0]      in_count,
    input  logic [ecm_pkg::LIMIT_BITS-1:0]      limit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [FRACTION_BITS:0]              out_t
);

    localparam int F     = FRACTION_BITS;
    localparam int LW    = ecm_pkg::LIMIT_BITS;
    localparam int CNT_W = (COUNT_BITS < ecm_pkg::FIELD_BITS) ? COUNT_BITS
                                                              : ecm_pkg::FIELD_BITS;

    logic          valid_reg [0:F];
    logic [LW-1:0] rem_reg   [0:F];
    logic [F-1:0]  quo_reg   [0:F];
    logic          sat_reg   [0:F];
    logic          ready     [0:F+1];

    logic [LW-1:0] limit_eff;
    logic [LW-1:0] count;
    logic          sat_next;

    assign limit_eff = (limit == '0) ? LW'(1) : limit;
    assign count     = LW'(in_count[CNT_W-1:0]);
    assign sat_next  = (count >= limit_eff);

    assign ready[F+1] = out_ready;
    assign in_ready   = ready[0];

    genvar k;
    generate
        for (k = 0; k <= F; k++)
        begin : g_ready
            assign ready[k] = !valid_reg[k] || ready[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ready[0])
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            rem_reg[0] <= sat_next ? '0 : count;
            quo_reg[0] <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    generate
        for (k = 1; k <= F; k++)
        begin : g_step
            logic [LW:0]   shifted;
            logic [LW:0]   diff;
            logic          ge;
            logic [LW-1:0] rem_next;
            logic [F-1:0]  quo_next;

            assign shifted  = {rem_reg[k-1], 1'b0};
            assign diff     = shifted - {1'b0, limit_eff};
            assign ge       = (shifted >= {1'b0, limit_eff});
            assign rem_next = ge ? diff[LW-1:0] : shifted[LW-1:0];
            assign quo_next = {quo_reg[k-1][F-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[k] && valid_reg[k-1])
                begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                    sat_reg[k] <= sat_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[F];
    assign out_t     = sat_reg[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo_reg[F]};

endmodule

// ===== rtl/ecm_poly.sv =====
`timescale 1ns / 1ps
// Five-stage pipeline that evaluates the three Bernstein color polynomials of t.
// Depends on ecm_pkg for the channel scales.
module ecm_poly #(
    parameter int FRACTION_BITS = ecm_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [FRACTION_BITS:0]            in_t,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ecm_pkg::CHAN_BITS-1:0]     out_red,
    output logic [ecm_pkg::CHAN_BITS-1:0]     out_green,
    output logic [ecm_pkg::CHAN_BITS-1:0]     out_blue
);

    localparam int F  = FRACTION_BITS;
    localparam int QW = F + 1;
    localparam int SW = QW + ecm_pkg::SCALE_BITS;
    localparam int HW = SW - F;
    localparam int NS = 5;

    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        begin
            p = (2*QW)'(a) * (2*QW)'(b);
            return p[F+QW-1:F];
        end
    endfunction

    function automatic logic [ecm_pkg::CHAN_BITS-1:0] scale(
        input logic [QW-1:0]                   p,
        input logic [ecm_pkg::SCALE_BITS-1:0]  k,
        input logic                            half
    );
        logic [SW-1:0] prod;
        logic [SW-1:0] sh;
        logic [HW-1:0] hi;
        begin
            prod = SW'(p) * SW'(k);
            sh   = half ? (prod >> 1) : prod;
            hi   = sh[SW-1:F];
            if (hi > HW'(ecm_pkg::CHAN_MAX))
            begin
                return ecm_pkg::CHAN_MAX;
            end
            return hi[ecm_pkg::CHAN_BITS-1:0];
        end
    endfunction

    logic vld_reg [1:NS];
    logic rdy     [1:NS+1];

    logic [QW-1:0] s1_t_reg, s1_u_reg;
    logic [QW-1:0] s2_t_reg, s2_u_reg, s2_tt_reg, s2_uu_reg;
    logic [QW-1:0] s3_t_reg, s3_u_reg, s3_ttt_reg, s3_uuu_reg, s3_pg_reg;
    logic [QW-1:0] s4_pr_reg, s4_pg_reg, s4_pb_reg;
    logic [ecm_pkg::CHAN_BITS-1:0] red_reg, green_reg, blue_reg;

    assign rdy[NS+1] = out_ready;
    assign in_ready  = rdy[1];

    genvar i;
    generate
        for (i = 1; i <= NS; i++)
        begin : g_ctl
            assign rdy[i] = !vld_reg[i] || rdy[i+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (rdy[i])
                begin
                    vld_reg[i] <= (i == 1) ? in_valid : vld_reg[(i == 1) ? 1 : i-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy[1] && in_valid)
        begin
            s1_t_reg <= in_t;
            s1_u_reg <= {1'b1, {F{1'b0}}} - in_t;
        end
        if (rdy[2] && vld_reg[1])
        begin
            s2_t_reg  <= s1_t_reg;
            s2_u_reg  <= s1_u_reg;
            s2_tt_reg <= qmul(s1_t_reg, s1_t_reg);
            s2_uu_reg <= qmul(s1_u_reg, s1_u_reg);
        end
        if (rdy[3] && vld_reg[2])
        begin
            s3_t_reg   <= s2_t_reg;
            s3_u_reg   <= s2_u_reg;
            s3_ttt_reg <= qmul(s2_tt_reg, s2_t_reg);
            s3_uuu_reg <= qmul(s2_uu_reg, s2_u_reg);
            s3_pg_reg  <= qmul(s2_uu_reg, s2_tt_reg);
        end
        if (rdy[4] && vld_reg[3])
        begin
            s4_pr_reg <= qmul(s3_u_reg, s3_ttt_reg);
            s4_pg_reg <= s3_pg_reg;
            s4_pb_reg <= qmul(s3_uuu_reg, s3_t_reg);
        end
        if (rdy[5] && vld_reg[4])
        begin
            red_reg   <= scale(s4_pr_reg, ecm_pkg::RED_SCALE, 1'b0);
            green_reg <= scale(s4_pg_reg, ecm_pkg::GREEN_SCALE, 1'b0);
            blue_reg  <= scale(s4_pb_reg, ecm_pkg::BLUE_SCALE, 1'b1);
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

// ===== rtl/escape_count_color_map.sv =====
`timescale 1ns / 1ps
// Top level of the escape count color map: configuration register and stream ports.
// Instantiates ecm_div and ecm_poly; depends on ecm_pkg.
//
// Each input word on s_axis carries one pixel's escape iteration count; each
// output word on m_axis carries the pixel's red, green and blue bytes.
// A count of zero gives black, and a count at or above max_iterations gives
// black as well. max_iterations is written through cfg_wr_en / cfg_wr_data
// and must only change while no pixel is in flight.
// The block takes and returns one word per cycle while m_axis is not stalled.
// The pipeline has one setup stage and one stage per quotient bit in the divider,
// then five polynomial stages.
// Every stage holds its own valid bit, so when m_axis stalls, the words move
// up into empty stages and s_axis_tready drops only once the whole pipeline
// is full. Nothing is lost or repeated under back pressure.
// Reset empties the pipeline and sets max_iterations to 500.
module escape_count_color_map #(
    parameter int COUNT_BITS    = ecm_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = ecm_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] iteration_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data     // max_iterations
);

    logic [ecm_pkg::LIMIT_BITS-1:0] max_iter_reg;
    logic                           div_valid;
    logic                           div_ready;
    logic [FRACTION_BITS:0]         div_t;
    logic [ecm_pkg::CHAN_BITS-1:0]  red;
    logic [ecm_pkg::CHAN_BITS-1:0]  green;
    logic [ecm_pkg::CHAN_BITS-1:0]  blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= ecm_pkg::MAX_ITER_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    ecm_div #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_count  (s_axis_tdata),
        .limit     (max_iter_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_t     (div_t)
    );

    ecm_poly #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_t      (div_t),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue)
    );

    assign m_axis_tdata = {blue, green, red};

    // Input back pressure only appears when the output itself is stalled.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output side is free");

    a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && !div_ready) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("divider stalled while the output side is free");

    a_cfg_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (max_iter_reg == ecm_pkg::MAX_ITER_RESET))
        else $error("max_iterations does not hold its reset value");

endmodule
